// ----- rtl/jmss_pkg.sv -----
package jmss_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    localparam logic [2:0] PH_FF      = 3'd0;
    localparam logic [2:0] PH_CODE    = 3'd1;
    localparam logic [2:0] PH_LEN_HI  = 3'd2;
    localparam logic [2:0] PH_LEN_LO  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_SCAN    = 3'd5;
    localparam logic [2:0] PH_SCAN_FF = 3'd6;
    localparam logic [2:0] PH_STOP    = 3'd7;

    localparam logic [3:0] KIND_SOI     = 4'd0;
    localparam logic [3:0] KIND_APP0    = 4'd1;
    localparam logic [3:0] KIND_DQT     = 4'd2;
    localparam logic [3:0] KIND_DHT     = 4'd3;
    localparam logic [3:0] KIND_SOF0    = 4'd4;
    localparam logic [3:0] KIND_SOS     = 4'd5;
    localparam logic [3:0] KIND_COM     = 4'd6;
    localparam logic [3:0] KIND_APP1    = 4'd7;
    localparam logic [3:0] KIND_APPN    = 4'd8;
    localparam logic [3:0] KIND_SOF2    = 4'd9;
    localparam logic [3:0] KIND_EOI     = 4'd10;
    localparam logic [3:0] KIND_UNKNOWN = 4'd11;

    localparam logic [7:0] BYTE_FF    = 8'hFF;
    localparam logic [7:0] BYTE_00    = 8'h00;
    localparam logic [7:0] CODE_SOI   = 8'hD8;
    localparam logic [7:0] CODE_APP0  = 8'hE0;
    localparam logic [7:0] CODE_DQT   = 8'hDB;
    localparam logic [7:0] CODE_DHT   = 8'hC4;
    localparam logic [7:0] CODE_SOF0  = 8'hC0;
    localparam logic [7:0] CODE_SOS   = 8'hDA;
    localparam logic [7:0] CODE_COM   = 8'hFE;
    localparam logic [7:0] CODE_APP1  = 8'hE1;
    localparam logic [7:0] CODE_APP2  = 8'hE2;
    localparam logic [7:0] CODE_APP15 = 8'hEF;
    localparam logic [7:0] CODE_SOF2  = 8'hC2;
    localparam logic [7:0] CODE_EOI   = 8'hD9;

    localparam logic [8:0] SEL_ALL = 9'h1FF;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       keep;
        logic       is_marker_code;
        logic [3:0] marker_kind;
        logic       in_scan_data;
        logic [7:0] scan_index;
        logic       image_done;
        logic       error;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       res0;
        res_t       res1;
    } push_t;

    function automatic logic [3:0] classify(input logic [7:0] c);
        logic [3:0] k;
        k = KIND_UNKNOWN;
        case (c) inside
            CODE_SOI:               k = KIND_SOI;
            CODE_APP0:              k = KIND_APP0;
            CODE_DQT:               k = KIND_DQT;
            CODE_DHT:               k = KIND_DHT;
            CODE_SOF0:              k = KIND_SOF0;
            CODE_SOS:               k = KIND_SOS;
            CODE_COM:               k = KIND_COM;
            CODE_APP1:              k = KIND_APP1;
            [CODE_APP2:CODE_APP15]: k = KIND_APPN;
            CODE_SOF2:              k = KIND_SOF2;
            CODE_EOI:               k = KIND_EOI;
            default:                k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic res_t mk_res(
        input logic [7:0] b,
        input logic       keep,
        input logic       code,
        input logic [3:0] kind,
        input logic       scan,
        input logic [7:0] idx,
        input logic       done,
        input logic       err
    );
        res_t r;
        r.out_byte       = b;
        r.keep           = keep;
        r.is_marker_code = code;
        r.marker_kind    = kind;
        r.in_scan_data   = scan;
        r.scan_index     = idx;
        r.image_done     = done;
        r.error          = err;
        r.last           = 1'b0;
        return r;
    endfunction

endpackage

// ----- rtl/jpeg_marker_scan_splitter.sv -----
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | data_byte
// out     | out_valid | out_stall | out_byte keep is_marker_code marker_kind in_scan_data
//         |           |           | scan_index image_done error last
// cfg     | cfg_valid | cfg_ready | cfg_data (scan_select)
//
// One input word per cycle while in_stall is low; a marker code or stuffed FF 00 yields two result words.
// Results are registered into a 4-word result queue whose head drives out_valid.
// in_stall rises when the queue holds more than two words; it frees as out drains.
// Reset clears the parser to expect the SOI marker FF and sets scan_select to -1.
// cfg_ready is always high.
module jpeg_marker_scan_splitter #(
    parameter int MAX_SCANS = 255
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       keep,
    output logic       is_marker_code,
    output logic [3:0] marker_kind,
    output logic       in_scan_data,
    output logic [7:0] scan_index,
    output logic       image_done,
    output logic       error,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [8:0] cfg_data
);
    import jmss_pkg::*;

    push_t push;
    res_t  head;
    logic  room;
    logic  go;

    assign cfg_ready = 1'b1;
    assign in_stall  = !room;
    assign go        = in_valid && room;

    jmss_parser #(
        .MAX_SCANS (MAX_SCANS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .go        (go),
        .data_byte (data_byte),
        .push      (push)
    );

    jmss_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign out_byte       = head.out_byte;
    assign keep           = head.keep;
    assign is_marker_code = head.is_marker_code;
    assign marker_kind    = head.marker_kind;
    assign in_scan_data   = head.in_scan_data;
    assign scan_index     = head.scan_index;
    assign image_done     = head.image_done;
    assign error          = head.error;
    assign last           = head.last;

endmodule

// ----- rtl/jmss_parser.sv -----
module jmss_parser #(
    parameter int MAX_SCANS = 255
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr,
    input  logic [8:0]     cfg_data,
    input  logic           go,
    input  logic [7:0]     data_byte,
    output jmss_pkg::push_t push
);
    import jmss_pkg::*;

    localparam int SCAN_LIMIT = (MAX_SCANS < 255) ? MAX_SCANS : 255;

    logic [8:0]  scan_select_reg;
    logic [2:0]  phase_reg, phase_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [3:0]  seg_kind_reg, seg_kind_next;
    logic        seg_keep_reg, seg_keep_next;
    logic [7:0]  scan_count_reg, scan_count_next;
    logic [7:0]  length_high_reg, length_high_next;

    logic [3:0]  kind;
    logic        sel_hit;
    logic        marker;
    logic [15:0] len;
    logic [15:0] bl_dec;
    res_t        r0, r1;
    logic [1:0]  n;

    assign kind    = classify(data_byte);
    assign sel_hit = (scan_select_reg == SEL_ALL) ||
                     (!scan_select_reg[8] && scan_select_reg[7:0] == scan_count_reg);
    assign len     = {length_high_reg, data_byte};
    assign bl_dec  = bytes_left_reg - 16'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        bytes_left_next  = bytes_left_reg;
        seg_kind_next    = seg_kind_reg;
        seg_keep_next    = seg_keep_reg;
        scan_count_next  = scan_count_reg;
        length_high_next = length_high_reg;
        marker           = 1'b0;
        n                = 2'd0;
        r0               = '0;
        r1               = '0;

        case (phase_reg)
            PH_FF:
            begin
                if (data_byte == BYTE_FF)
                begin
                    phase_next = PH_CODE;
                end
                else
                begin
                    n          = 2'd1;
                    r0         = mk_res(data_byte, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0,
                                        scan_count_reg, 1'b0, 1'b1);
                    phase_next = PH_STOP;
                end
            end
            PH_CODE:
            begin
                marker = 1'b1;
            end
            PH_LEN_HI:
            begin
                length_high_next = data_byte;
                n                = 2'd1;
                r0               = mk_res(data_byte, seg_keep_reg, 1'b0, seg_kind_reg, 1'b0,
                                          scan_count_reg, 1'b0, 1'b0);
                phase_next       = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                n = 2'd1;
                if (len < 16'd2)
                begin
                    r0         = mk_res(data_byte, 1'b0, 1'b0, seg_kind_reg, 1'b0,
                                        scan_count_reg, 1'b0, 1'b1);
                    phase_next = PH_STOP;
                end
                else
                begin
                    r0              = mk_res(data_byte, seg_keep_reg, 1'b0, seg_kind_reg, 1'b0,
                                             scan_count_reg, 1'b0, 1'b0);
                    bytes_left_next = len - 16'd2;
                    if (len != 16'd2)
                        phase_next = PH_PAYLOAD;
                    else if (seg_kind_reg == KIND_SOS)
                        phase_next = PH_SCAN;
                    else
                        phase_next = PH_FF;
                end
            end
            PH_PAYLOAD:
            begin
                n               = 2'd1;
                r0              = mk_res(data_byte, seg_keep_reg, 1'b0, seg_kind_reg, 1'b0,
                                         scan_count_reg, 1'b0, 1'b0);
                bytes_left_next = bl_dec;
                if (bl_dec == 16'd0)
                    phase_next = (seg_kind_reg == KIND_SOS) ? PH_SCAN : PH_FF;
            end
            PH_SCAN:
            begin
                if (data_byte == BYTE_FF)
                begin
                    phase_next = PH_SCAN_FF;
                end
                else
                begin
                    n  = 2'd1;
                    r0 = mk_res(data_byte, seg_keep_reg, 1'b0, seg_kind_reg, 1'b1,
                                scan_count_reg, 1'b0, 1'b0);
                end
            end
            PH_SCAN_FF:
            begin
                if (data_byte == BYTE_00)
                begin
                    n          = 2'd2;
                    r0         = mk_res(BYTE_FF, seg_keep_reg, 1'b0, seg_kind_reg, 1'b1,
                                        scan_count_reg, 1'b0, 1'b0);
                    r1         = mk_res(data_byte, seg_keep_reg, 1'b0, seg_kind_reg, 1'b1,
                                        scan_count_reg, 1'b0, 1'b0);
                    phase_next = PH_SCAN;
                end
                else
                begin
                    marker = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_STOP;
            end
        endcase

        if (marker)
        begin
            n = 2'd2;
            if (kind == KIND_UNKNOWN)
            begin
                r0         = mk_res(BYTE_FF, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0,
                                    scan_count_reg, 1'b0, 1'b0);
                r1         = mk_res(data_byte, 1'b0, 1'b1, KIND_UNKNOWN, 1'b0,
                                    scan_count_reg, 1'b0, 1'b1);
                phase_next = PH_STOP;
            end
            else
            begin
                if (kind == KIND_SOS)
                begin
                    seg_keep_next = sel_hit;
                    if (scan_count_reg < 8'(SCAN_LIMIT))
                        scan_count_next = scan_count_reg + 8'd1;
                end
                else
                begin
                    seg_keep_next = 1'b1;
                end
                seg_kind_next = kind;
                r0 = mk_res(BYTE_FF, seg_keep_next, 1'b0, kind, 1'b0,
                            scan_count_next, 1'b0, 1'b0);
                r1 = mk_res(data_byte, seg_keep_next, 1'b1, kind, 1'b0,
                            scan_count_next, kind == KIND_EOI, 1'b0);
                if (kind == KIND_SOI)
                    phase_next = PH_FF;
                else if (kind == KIND_EOI)
                    phase_next = PH_STOP;
                else
                    phase_next = PH_LEN_HI;
            end
        end

        if (n == 2'd1)
            r0.last = 1'b1;
        if (n == 2'd2)
            r1.last = 1'b1;
    end

    always_comb
    begin
        push.count = go ? n : 2'd0;
        push.res0  = r0;
        push.res1  = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_select_reg <= SEL_ALL;
            phase_reg       <= PH_FF;
            bytes_left_reg  <= '0;
            seg_kind_reg    <= KIND_SOI;
            seg_keep_reg    <= 1'b1;
            scan_count_reg  <= '0;
            length_high_reg <= '0;
        end
        else
        begin
            if (cfg_wr)
                scan_select_reg <= cfg_data;
            if (go)
            begin
                phase_reg       <= phase_next;
                bytes_left_reg  <= bytes_left_next;
                seg_kind_reg    <= seg_kind_next;
                seg_keep_reg    <= seg_keep_next;
                scan_count_reg  <= scan_count_next;
                length_high_reg <= length_high_next;
            end
        end
    end

    a_stop_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        go && ((push.count != 2'd0 && push.res0.error) ||
               (push.count == 2'd2 && push.res1.error)) |=> phase_reg == PH_STOP)
        else $error("parser kept running after an error");

    a_stop_silent: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_STOP |-> n == 2'd0)
        else $error("result produced while stopped");

    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        go && push.count == 2'd2 |-> push.res1.last && !push.res0.last)
        else $error("last flag misplaced on a result pair");

    a_scan_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        go && phase_reg != PH_STOP |=> scan_count_reg <= 8'(SCAN_LIMIT))
        else $error("scan count beyond its limit");

endmodule

// ----- rtl/jmss_out_fifo.sv -----
module jmss_out_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  jmss_pkg::push_t push,
    output logic            room,
    output logic            out_valid,
    input  logic            out_stall,
    output jmss_pkg::res_t  head
);
    import jmss_pkg::*;

    res_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign out_valid  = (count_reg != '0);
    assign pop        = out_valid && !out_stall;
    assign room       = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign head       = mem[rd_reg];
    assign wr_next    = wr_reg + PTR_W'(push.count);
    assign rd_next    = rd_reg + PTR_W'(pop);
    assign count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_reg] <= push.res0;
        if (push.count == 2'd2)
            mem[PTR_W'(wr_reg + PTR_W'(1))] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> room)
        else $error("result words pushed without room");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

endmodule
